### design/irpwd_pkg.sv
// Shared types, constants and register map for the IR pulse-width decoder.
package irpwd_pkg;

    localparam int PULSE_W    = 24;
    localparam int REG_W      = 16;
    localparam int WORD_W     = 31;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    localparam int CODE_BITS_DEF = 31;

    localparam logic [REG_W-1:0] START_MIN_RST = 16'd2100;
    localparam logic [REG_W-1:0] START_MAX_RST = 16'd2800;
    localparam logic [REG_W-1:0] LOW_MIN_RST   = 16'd300;
    localparam logic [REG_W-1:0] LOW_MAX_RST   = 16'd900;
    localparam logic [REG_W-1:0] HIGH_MIN_RST  = 16'd1000;
    localparam logic [REG_W-1:0] HIGH_MAX_RST  = 16'd1600;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_START_MIN = 3'd0,
        REG_START_MAX = 3'd1,
        REG_LOW_MIN   = 3'd2,
        REG_LOW_MAX   = 3'd3,
        REG_HIGH_MIN  = 3'd4,
        REG_HIGH_MAX  = 3'd5
    } reg_idx_t;

    typedef enum logic {
        EV_CODE     = 1'b0,
        EV_OVERFLOW = 1'b1
    } event_kind_t;

    typedef struct packed {
        logic [REG_W-1:0] start_min;
        logic [REG_W-1:0] start_max;
        logic [REG_W-1:0] low_min;
        logic [REG_W-1:0] low_max;
        logic [REG_W-1:0] high_min;
        logic [REG_W-1:0] high_max;
    } thresholds_t;

    typedef struct packed {
        logic frame_end;
        logic start_ok;
        logic in_high;
        logic in_low;
    } window_hits_t;

endpackage

### design/irpwd_regs.sv
// Threshold register file behind the APB-style configuration port.
module irpwd_regs
    import irpwd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output thresholds_t           thr
);

    thresholds_t      thr_reg;
    logic             wr_en;
    logic [REG_W-1:0] rd_val;
    reg_idx_t         idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign thr    = thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.start_min <= START_MIN_RST;
            thr_reg.start_max <= START_MAX_RST;
            thr_reg.low_min   <= LOW_MIN_RST;
            thr_reg.low_max   <= LOW_MAX_RST;
            thr_reg.high_min  <= HIGH_MIN_RST;
            thr_reg.high_max  <= HIGH_MAX_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_START_MIN: thr_reg.start_min <= pwdata[REG_W-1:0];
                REG_START_MAX: thr_reg.start_max <= pwdata[REG_W-1:0];
                REG_LOW_MIN:   thr_reg.low_min   <= pwdata[REG_W-1:0];
                REG_LOW_MAX:   thr_reg.low_max   <= pwdata[REG_W-1:0];
                REG_HIGH_MIN:  thr_reg.high_min  <= pwdata[REG_W-1:0];
                REG_HIGH_MAX:  thr_reg.high_max  <= pwdata[REG_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_START_MIN: rd_val = thr_reg.start_min;
            REG_START_MAX: rd_val = thr_reg.start_max;
            REG_LOW_MIN:   rd_val = thr_reg.low_min;
            REG_LOW_MAX:   rd_val = thr_reg.low_max;
            REG_HIGH_MIN:  rd_val = thr_reg.high_min;
            REG_HIGH_MAX:  rd_val = thr_reg.high_max;
            default:       rd_val = '0;
        endcase
    end

    assign prdata = APB_DATA_W'(rd_val);

endmodule

### design/irpwd_classify.sv
// Window comparators: sort one interval into start, one-bit and zero-bit windows.
module irpwd_classify
    import irpwd_pkg::*;
(
    input  logic [PULSE_W-1:0] pulse,
    input  thresholds_t        thr,
    output window_hits_t       hits
);

    always_comb
    begin
        hits.frame_end = pulse >  PULSE_W'(thr.start_min);
        hits.start_ok  = pulse <= PULSE_W'(thr.start_max);
        hits.in_high   = (pulse > PULSE_W'(thr.high_min)) && (pulse < PULSE_W'(thr.high_max));
        hits.in_low    = (pulse > PULSE_W'(thr.low_min))  && (pulse < PULSE_W'(thr.low_max));
    end

endmodule

### design/irpwd_collector.sv
// Bit collector state and the result decision for one classified interval.
module irpwd_collector
    import irpwd_pkg::*;
#(
    parameter int CODE_BITS = CODE_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  window_hits_t      hits,
    output logic              emit,
    output event_kind_t       kind,
    output logic [WORD_W-1:0] word
);

    localparam int CNT_W = $clog2(CODE_BITS + 1);

    logic                 clear_pending_reg, clear_pending_next;
    logic [CNT_W-1:0]     bit_count_reg, bit_count_next;
    logic [CODE_BITS-1:0] code_bits_reg, code_bits_next;
    logic                 mark_seen_reg, mark_seen_next;
    logic [CNT_W-1:0]     cnt0;
    logic [CODE_BITS-1:0] code0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_pending_reg <= 1'b1;
            bit_count_reg     <= '0;
            code_bits_reg     <= '0;
            mark_seen_reg     <= 1'b0;
        end
        else if (step)
        begin
            clear_pending_reg <= clear_pending_next;
            bit_count_reg     <= bit_count_next;
            code_bits_reg     <= code_bits_next;
            mark_seen_reg     <= mark_seen_next;
        end
    end

    always_comb
    begin
        // Apply a pending clear before looking at the interval.
        cnt0  = clear_pending_reg ? '0 : bit_count_reg;
        code0 = clear_pending_reg ? '0 : code_bits_reg;

        clear_pending_next = 1'b0;
        bit_count_next     = cnt0;
        code_bits_next     = code0;
        mark_seen_next     = mark_seen_reg;
        emit               = 1'b0;
        kind               = EV_CODE;
        word               = WORD_W'(code0);

        if (hits.frame_end)
        begin
            emit               = |code0;
            clear_pending_next = 1'b1;
            mark_seen_next     = hits.start_ok;
        end
        else if (cnt0 >= CNT_W'(CODE_BITS))
        begin
            emit               = 1'b1;
            kind               = EV_OVERFLOW;
            word               = '0;
            clear_pending_next = 1'b1;
        end
        else if (hits.in_high)
        begin
            code_bits_next = code0 | (CODE_BITS'(1) << cnt0);
            bit_count_next = cnt0 + CNT_W'(1);
            mark_seen_next = 1'b1;
        end
        else if (hits.in_low)
        begin
            if (!mark_seen_reg)
            begin
                bit_count_next = cnt0 + CNT_W'(1);
                mark_seen_next = 1'b1;
            end
            else
            begin
                mark_seen_next = 1'b0;
            end
        end
    end

endmodule

### design/ir_pulse_width_decoder.sv
// Top level of the IR pulse-width decoder: input register, collector, result register.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------
//  pulse    | pulse_valid / pulse_ready  | pulse_us[23:0]
//  event    | event_valid / event_ready  | event_kind, code_word[30:0]
//  config   | psel/penable/pwrite/pready | paddr[4:0], pwdata, prdata
//
// One interval per cycle is sustained while events are taken: a transfer lands in
// the input register, and on a step the comparators and collector update the state
// and load the result register. The result register holds a finished event, and
// while it waits a new interval is taken only into an empty input register. Reset
// loads the default thresholds, empties both registers and leaves a clear pending.
// A stalled event freezes the collector state at once, and the input register once
// it is full.
module ir_pulse_width_decoder
    import irpwd_pkg::*;
#(
    parameter int CODE_BITS = CODE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pulse_valid,
    output logic                  pulse_ready,
    input  logic [PULSE_W-1:0]    pulse_us,
    output logic                  event_valid,
    input  logic                  event_ready,
    output logic                  event_kind,
    output logic [WORD_W-1:0]     code_word,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    thresholds_t        thr;
    window_hits_t       hits;
    logic               s1_valid_reg;
    logic [PULSE_W-1:0] s1_pulse_reg;
    logic               out_valid_reg;
    event_kind_t        out_kind_reg;
    logic [WORD_W-1:0]  out_word_reg;
    logic               advance;
    logic               step;
    logic               emit;
    event_kind_t        kind;
    logic [WORD_W-1:0]  word;

    // The stored interval may move on when the result register is free or draining.
    assign advance     = !out_valid_reg || event_ready;
    assign step        = s1_valid_reg && advance;
    assign pulse_ready = !s1_valid_reg || advance;

    irpwd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .thr     (thr)
    );

    // Hold the accepted interval in the input register ahead of the comparators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pulse_ready)
        begin
            s1_valid_reg <= pulse_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pulse_valid && pulse_ready)
        begin
            s1_pulse_reg <= pulse_us;
        end
    end

    irpwd_classify u_classify (
        .pulse (s1_pulse_reg),
        .thr   (thr),
        .hits  (hits)
    );

    irpwd_collector #(
        .CODE_BITS (CODE_BITS)
    ) u_collector (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .hits  (hits),
        .emit  (emit),
        .kind  (kind),
        .word  (word)
    );

    // Result register: load on a step, drop when taken and nothing replaces it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            out_kind_reg <= kind;
            out_word_reg <= word;
        end
    end

    assign event_valid = out_valid_reg;
    assign event_kind  = out_kind_reg;
    assign code_word   = out_word_reg;

endmodule

### design/irpwd_checker.sv
// Port-level checks for the IR pulse-width decoder, bound to the top level.
module irpwd_checker
    import irpwd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              pulse_ready,
    input logic              event_valid,
    input logic              event_ready,
    input logic              event_kind,
    input logic [WORD_W-1:0] code_word,
    input logic              pready
);

    a_event_hold: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && !event_ready |=> event_valid && $stable(event_kind) && $stable(code_word))
        else $error("event dropped or changed while stalled");

    a_overflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && (event_kind == EV_OVERFLOW) |-> code_word == '0)
        else $error("overflow event carries a code word");

    a_code_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && (event_kind == EV_CODE) |-> code_word != '0)
        else $error("empty code word emitted");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !pulse_ready |-> event_valid && !event_ready)
        else $error("pulse channel stalled without a blocked event");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind ir_pulse_width_decoder irpwd_checker u_irpwd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pulse_ready (pulse_ready),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .event_kind  (event_kind),
    .code_word   (code_word),
    .pready      (pready)
);

### bench/tb_ir_pulse_width_decoder.sv
// Self-checking testbench for the IR pulse-width decoder: pulse stimulus, event scoreboard.
module tb_ir_pulse_width_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import irpwd_pkg::*;

    // Collector length of the instance under test, and the register count of the map.
    localparam int NBITS          = CODE_BITS_DEF;
    localparam int N_REGS         = 6;
    // Indexes past the map; writes there must leave every threshold alone.
    localparam int REG_SPARE_LO   = 6;
    localparam int REG_SPARE_HI   = 7;
    // Settling margin after the last pulse transfer and event.
    localparam int TAIL_CYCLES    = 8;
    // Cycles without any transfer before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        event_kind_t           kind;
        logic [WORD_W-1:0]     word;
    } code_event_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  pulse_valid = 1'b0;
    logic                  pulse_ready;
    logic [PULSE_W-1:0]    pulse_us    = '0;
    logic                  event_valid;
    logic                  event_ready = 1'b0;
    logic                  event_kind;
    logic [WORD_W-1:0]     code_word;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ir_pulse_width_decoder #(
        .CODE_BITS   (NBITS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pulse_valid (pulse_valid),
        .pulse_ready (pulse_ready),
        .pulse_us    (pulse_us),
        .event_valid (event_valid),
        .event_ready (event_ready),
        .event_kind  (event_kind),
        .code_word   (code_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Shadow of the decoder: thresholds plus the collector state.
    // ------------------------------------------------------------------
    logic [REG_W-1:0]  thr_regs [N_REGS];
    bit                clear_pend;
    int                n_bits;
    logic [63:0]       code_acc;
    bit                mark;

    logic [PULSE_W-1:0] pending_pulses [$];
    code_event_t        expected_events [$];

    int  n_queued;
    int  n_pulses;
    int  n_code_words;
    int  n_overflows;
    int  n_reg_writes;
    int  mismatches;
    int  quiet_cycles;
    bit  pulse_sent;
    bit  idle_on;
    int  tx_gap;
    int  rx_gap;

    function automatic void flag_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("%0t ns: %s", $time, what);
        end
    endfunction

    function automatic void reset_shadow();
        thr_regs[REG_START_MIN] = START_MIN_RST;
        thr_regs[REG_START_MAX] = START_MAX_RST;
        thr_regs[REG_LOW_MIN]   = LOW_MIN_RST;
        thr_regs[REG_LOW_MAX]   = LOW_MAX_RST;
        thr_regs[REG_HIGH_MIN]  = HIGH_MIN_RST;
        thr_regs[REG_HIGH_MAX]  = HIGH_MAX_RST;
        clear_pend = 1'b1;
        n_bits     = 0;
        code_acc   = '0;
        mark       = 1'b0;
    endfunction

    // Advance the shadow collector by one interval and queue the event it raises, if any.
    function automatic void decode_interval(input logic [PULSE_W-1:0] p);
        code_event_t ev;
        if (clear_pend)
        begin
            clear_pend = 1'b0;
            n_bits     = 0;
            code_acc   = '0;
        end
        // A long interval closes the frame; an empty collector stays silent.
        if (p > thr_regs[REG_START_MIN])
        begin
            if (code_acc != 0)
            begin
                ev.kind = EV_CODE;
                ev.word = code_acc[WORD_W-1:0];
                expected_events.push_back(ev);
            end
            clear_pend = 1'b1;
            mark       = (p <= thr_regs[REG_START_MAX]);
            return;
        end
        // Full collector: any further non-closing interval is an overflow.
        if (n_bits >= NBITS)
        begin
            clear_pend = 1'b1;
            ev.kind    = EV_OVERFLOW;
            ev.word    = '0;
            expected_events.push_back(ev);
            return;
        end
        // High window wins where the windows overlap.
        if (p > thr_regs[REG_HIGH_MIN] && p < thr_regs[REG_HIGH_MAX])
        begin
            code_acc[n_bits] = 1'b1;
            n_bits++;
            mark = 1'b1;
        end
        else if (p > thr_regs[REG_LOW_MIN] && p < thr_regs[REG_LOW_MAX])
        begin
            // After a mark a short interval is only the gap between bits.
            if (!mark)
            begin
                n_bits++;
                mark = 1'b1;
            end
            else
            begin
                mark = 1'b0;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Pulse driver: hold each transfer until taken, then advance the queue.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : pulse_driver
        logic               nv;
        logic [PULSE_W-1:0] np;
        nv = pulse_valid;
        np = pulse_us;
        if (pulse_valid && pulse_sent)
        begin
            nv = 1'b0;
        end
        if (rst_n && !nv && pending_pulses.size() != 0)
        begin
            if (tx_gap != 0)
            begin
                tx_gap--;
            end
            else if (idle_on && $urandom_range(0, 6) == 0)
            begin
                // Idle this cycle and start a random gap after it.
                tx_gap = $urandom_range(0, 9);
            end
            else
            begin
                np = pending_pulses.pop_front();
                nv = 1'b1;
            end
        end
        pulse_sent = 1'b0;
        pulse_valid <= nv;
        pulse_us    <= np;
    end

    // ------------------------------------------------------------------
    // Event sink: drop ready in random bursts while idling is on.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : event_sink
        logic r;
        if (!rst_n)
        begin
            r = 1'b0;
        end
        else if (rx_gap != 0)
        begin
            rx_gap--;
            r = 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            rx_gap = $urandom_range(0, 9);
            r      = 1'b0;
        end
        else
        begin
            r = 1'b1;
        end
        event_ready <= r;
    end

    // ------------------------------------------------------------------
    // Monitor: check each event transfer against the oldest expectation,
    // then predict from the pulse taken at the same edge. An event can
    // never come from a pulse of the same edge, so check first.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        code_event_t want;
        bit          moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (event_valid && event_ready)
            begin
                moved = 1'b1;
                if (event_kind == EV_OVERFLOW)
                begin
                    n_overflows++;
                end
                else
                begin
                    n_code_words++;
                end
                if (expected_events.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected event: kind %0d word 0x%08h",
                                            event_kind, code_word));
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (event_kind !== want.kind)
                    begin
                        flag_mismatch($sformatf("event_kind: expected %0d, got %0d",
                                                want.kind, event_kind));
                    end
                    if (code_word !== want.word)
                    begin
                        flag_mismatch($sformatf("code_word: expected 0x%08h, got 0x%08h",
                                                want.word, code_word));
                    end
                end
            end
            if (pulse_valid && pulse_ready)
            begin
                moved      = 1'b1;
                pulse_sent = 1'b1;
                n_pulses++;
                decode_interval(pulse_us);
            end
        end
        // Watchdog: a long stretch with no transfer on either channel means a hang.
        if (moved || !rst_n)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d events still owed",
                     WATCHDOG_LIMIT, expected_events.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_pulse(input int v);
        pending_pulses.push_back(v[PULSE_W-1:0]);
        n_queued++;
    endfunction

    // Value strictly inside (lo, hi); any 16-bit value if the window is empty.
    function automatic int pick_open(input int lo, input int hi);
        if (hi - lo >= 2)
        begin
            return $urandom_range(lo + 1, hi - 1);
        end
        return $urandom_range(0, 65535);
    endfunction

    function automatic int pick_start();
        int lo;
        int hi;
        lo = thr_regs[REG_START_MIN];
        hi = thr_regs[REG_START_MAX];
        if (hi > lo)
        begin
            return $urandom_range(lo + 1, hi);
        end
        return $urandom_range(lo + 1, lo + 4000);
    endfunction

    // Frame end beyond the start maximum: the faulty-start path.
    function automatic int pick_long();
        int lo;
        lo = thr_regs[REG_START_MAX] > thr_regs[REG_START_MIN] ?
             thr_regs[REG_START_MAX] : thr_regs[REG_START_MIN];
        if ($urandom_range(0, 7) == 0)
        begin
            return 24'hFFFFFF;
        end
        return $urandom_range(lo + 1, 24'hFFFFFF);
    endfunction

    function automatic int pick_noise();
        int b;
        int v;
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 24'hFFFFFF);
            1: return $urandom_range(0, thr_regs[REG_START_MIN]);
            2:
            begin
                // Land on or next to a threshold.
                b = thr_regs[$urandom_range(0, N_REGS - 1)];
                v = b + int'($urandom_range(0, 2)) - 1;
                return (v < 0) ? 0 : v;
            end
            3: return $urandom_range(0, 1) ? 24'hFFFFFF : 0;
            default: return $urandom_range(0, 4000);
        endcase
    endfunction

    // Well-formed frame: start, then space plus data interval per bit, then the closing start.
    // Now and then drop a space, slip in noise or use a faulty start to break the rhythm.
    function automatic void queue_frame(input int nbits);
        int i;
        queue_pulse(($urandom_range(0, 4) == 0) ? pick_long() : pick_start());
        for (i = 0; i < nbits; i++)
        begin
            if ($urandom_range(0, 15) != 0)
            begin
                queue_pulse(pick_open(thr_regs[REG_LOW_MIN], thr_regs[REG_LOW_MAX]));
            end
            if ($urandom_range(0, 31) == 0)
            begin
                queue_pulse(pick_noise());
            end
            if ($urandom_range(0, 1) != 0)
            begin
                queue_pulse(pick_open(thr_regs[REG_HIGH_MIN], thr_regs[REG_HIGH_MAX]));
            end
            else
            begin
                queue_pulse(pick_open(thr_regs[REG_LOW_MIN], thr_regs[REG_LOW_MAX]));
            end
        end
        queue_pulse(($urandom_range(0, 4) == 0) ? pick_long() : pick_start());
    endfunction

    // Mostly ordinary frames, some that run past the collector, some loose noise.
    function automatic void queue_random(input int budget);
        int first;
        first = n_queued;
        while (n_queued - first < budget)
        begin
            case ($urandom_range(0, 9))
                0, 1: repeat ($urandom_range(1, 6)) queue_pulse(pick_noise());
                2: queue_frame($urandom_range(NBITS - 2, NBITS + 3));
                default: queue_frame($urandom_range(1, 20));
            endcase
        end
    endfunction

    // Hold until every pulse is taken and every event is in, then let the pipe settle.
    task automatic wait_idle();
        while (pending_pulses.size() != 0 || pulse_valid || expected_events.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_read_check(input int idx);
        logic [APB_DATA_W-1:0] rd;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_ADDR_W'(idx * 4);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[REG_W-1:0] !== thr_regs[idx])
        begin
            flag_mismatch($sformatf("register %0d read: expected 0x%04h, got 0x%04h",
                                    idx, thr_regs[idx], rd[REG_W-1:0]));
        end
    endtask

    // Write with junk in the upper half of the bus; only the low 16 bits count.
    task automatic cfg_write(input int idx, input int val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx * 4);
        pwdata  <= {16'($urandom_range(0, 65535)), 16'(val)};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx < N_REGS)
        begin
            thr_regs[idx] = val[REG_W-1:0];
        end
        n_reg_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < N_REGS)
        begin
            cfg_read_check(idx);
        end
    endtask

    task automatic write_windows(input int smin, input int smax, input int lmin,
                                 input int lmax, input int hmin, input int hmax);
        cfg_write(REG_START_MIN, smin);
        cfg_write(REG_START_MAX, smax);
        cfg_write(REG_LOW_MIN,   lmin);
        cfg_write(REG_LOW_MAX,   lmax);
        cfg_write(REG_HIGH_MIN,  hmin);
        cfg_write(REG_HIGH_MAX,  hmax);
    endtask

    // ------------------------------------------------------------------
    // Run sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int i;
        int lmin;
        int lmax;
        int hmin;
        int hmax;
        int smin;
        reset_shadow();
        n_queued     = 0;
        n_pulses     = 0;
        n_code_words = 0;
        n_overflows  = 0;
        n_reg_writes = 0;
        mismatches   = 0;
        quiet_cycles = 0;
        pulse_sent   = 1'b0;
        idle_on      = 1'b1;
        tx_gap       = 0;
        rx_gap       = 0;

        // Hold reset, then release it on a falling edge.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset thresholds must read back as the defaults.
        for (i = 0; i < N_REGS; i++)
        begin
            cfg_read_check(i);
        end

        // Directed: window edges (both bounds exclusive, start max inclusive),
        // an empty frame end, a faulty start, a space after a mark, an ignored
        // interval, a short code word and the input extremes.
        queue_pulse(0);
        queue_pulse(24'hFFFFFF);
        queue_pulse(2800);
        queue_pulse(300);
        queue_pulse(900);
        queue_pulse(301);
        queue_pulse(1600);
        queue_pulse(1599);
        queue_pulse(899);
        queue_pulse(1001);
        queue_pulse(899);
        queue_pulse(1000);
        queue_pulse(500);
        queue_pulse(2100);
        queue_pulse(2101);
        queue_pulse(2801);
        queue_pulse(65535);
        queue_pulse(1);
        // Pause the sender until every owed event has come back.
        wait_idle();

        // Force one overflow under the defaults, then random traffic.
        queue_frame(NBITS + 2);
        queue_random(380);
        wait_idle();

        // Narrow, well separated windows near the bottom of the range.
        lmin = $urandom_range(5, 30);
        lmax = lmin + $urandom_range(10, 40);
        hmin = lmax + $urandom_range(0, 10);
        hmax = hmin + $urandom_range(10, 40);
        smin = hmax + $urandom_range(5, 40);
        write_windows(smin, smin + $urandom_range(20, 80), lmin, lmax, hmin, hmax);
        queue_random(400);
        wait_idle();

        // Extremes: all windows wide open and overlapping, start max below
        // start min so every frame end leaves the mark clear. No idling here.
        idle_on = 1'b0;
        write_windows(16'hFFFF, 0, 0, 16'hFFFF, 0, 16'hFFFF);
        queue_random(250);
        wait_idle();
        idle_on = 1'b1;

        // Opposite extremes: every nonzero interval ends a frame, windows empty.
        write_windows(0, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF, 0);
        queue_random(100);
        wait_idle();

        // Random ordered windows, then writes past the map that must change nothing.
        lmin = $urandom_range(0, 2000);
        lmax = lmin + $urandom_range(2, 1500);
        hmin = lmax + $urandom_range(0, 500);
        hmax = hmin + $urandom_range(2, 1500);
        smin = hmax + $urandom_range(0, 1000);
        write_windows(smin, smin + $urandom_range(0, 1000), lmin, lmax, hmin, hmax);
        cfg_write(REG_SPARE_LO, $urandom_range(0, 65535));
        cfg_write(REG_SPARE_HI, $urandom_range(0, 65535));
        for (i = 0; i < N_REGS; i++)
        begin
            cfg_read_check(i);
        end
        queue_random(400);
        wait_idle();

        // Back to the defaults for the closing stretch, both sides flat out.
        idle_on = 1'b0;
        write_windows(START_MIN_RST, START_MAX_RST, LOW_MIN_RST, LOW_MAX_RST,
                      HIGH_MIN_RST, HIGH_MAX_RST);
        queue_random(400);
        wait_idle();

        if (expected_events.size() != 0)
        begin
            flag_mismatch($sformatf("%0d events never arrived", expected_events.size()));
        end
        $display("Run covered %0d pulse transfers under 6 threshold settings, %0d register writes.",
                 n_pulses, n_reg_writes);
        $display("Events seen: %0d code words, %0d overflows; %0d mismatches.",
                 n_code_words, n_overflows, mismatches);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
